@@ rtl/pva_pkg.sv @@
`default_nettype none
package pva_pkg;

	localparam int VOICES        = 64;
	localparam int PRIORITY_BITS = 8;
	localparam int IDX_W         = (VOICES > 1) ? $clog2(VOICES) : 1;

	localparam logic [1:0] ACT_ACQUIRE  = 2'd0;
	localparam logic [1:0] ACT_FREE     = 2'd1;
	localparam logic [1:0] ACT_SET_PRIO = 2'd2;

	localparam logic [1:0] ST_FREE_GRANT  = 2'd0;
	localparam logic [1:0] ST_STEAL_GRANT = 2'd1;
	localparam logic [1:0] ST_REFUSED     = 2'd2;
	localparam logic [1:0] ST_DONE        = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] voice;
		logic [7:0] priority_req;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] granted_voice;
	} rsp_item_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                     valid;
		logic                     free_found;
		logic [IDX_W-1:0]         free_idx;
		logic                     victim_found;
		logic [IDX_W-1:0]         victim_idx;
		logic [PRIORITY_BITS-1:0] victim_prio;
	} scan_t;

	typedef struct packed {
		logic                     use_en;
		logic                     use_val;
		logic                     prio_en;
		logic [PRIORITY_BITS-1:0] prio_val;
	} cell_wr_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

endpackage
`default_nettype wire

@@ rtl/priority_voice_allocator.sv @@
`default_nettype none
// Voice allocator for a pool of VOICES voices, each with a used flag and a
// priority. Free and set-priority items have their result valid the cycle
// after the item is taken. An acquire item launches a search token down a
// chain of one cell per voice, one cell per cycle, and its result is
// registered from the token that leaves the last cell, so the length of the
// cell chain sets when it is valid. One item is in work at a time,
// and a new item is taken only once the previous result has been taken (or
// is being taken in the same cycle). Reset frees every voice and sets every
// priority to zero.
module priority_voice_allocator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire pva_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output pva_pkg::rsp_item_t      rsp
);
	import pva_pkg::*;

	fsm_t                     state_q;
	fsm_t                     state_d;
	logic [PRIORITY_BITS-1:0] req_prio_q;
	logic [PRIORITY_BITS-1:0] new_prio;
	logic [PRIORITY_BITS-1:0] scan_prio;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_q;
	logic                     accept;
	logic                     voice_ok;
	logic                     load_rsp;
	rsp_item_t                rsp_d;

	logic                     wr_use_en;
	logic                     wr_prio_en;
	logic                     wr_use_val;
	logic [IDX_W-1:0]         wr_idx;
	logic [PRIORITY_BITS-1:0] wr_prio_val;

	scan_t                    chain [VOICES+1];
	scan_t                    tail;

	assign accept    = req_valid && req_ready;
	assign new_prio  = PRIORITY_BITS'(req.priority_req);
	assign voice_ok  = (32'(req.voice) < 32'(VOICES));
	assign scan_prio = (state_q == FSM_IDLE) ? new_prio : req_prio_q;
	assign tail      = chain[VOICES];

	always_comb begin
		chain[0]              = '0;
		chain[0].valid        = accept && (req.action == ACT_ACQUIRE);
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		load_rsp    = 1'b0;
		rsp_d       = '0;
		wr_use_en   = 1'b0;
		wr_use_val  = 1'b0;
		wr_prio_en  = 1'b0;
		wr_idx      = '0;
		wr_prio_val = new_prio;
		unique case (state_q)
			FSM_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				if (accept) begin
					case (req.action)
						ACT_ACQUIRE: begin
							state_d = FSM_SCAN;
						end
						ACT_FREE: begin
							load_rsp     = 1'b1;
							rsp_d.status = ST_DONE;
							wr_idx       = IDX_W'(req.voice);
							wr_use_en    = voice_ok;
						end
						ACT_SET_PRIO: begin
							load_rsp     = 1'b1;
							rsp_d.status = ST_DONE;
							wr_idx       = IDX_W'(req.voice);
							wr_prio_en   = voice_ok;
						end
						default: begin
							load_rsp     = 1'b1;
							rsp_d.status = ST_REFUSED;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				wr_prio_val = req_prio_q;
				wr_use_val  = 1'b1;
				if (tail.valid) begin
					state_d  = FSM_IDLE;
					load_rsp = 1'b1;
					if (tail.free_found) begin
						rsp_d.status        = ST_FREE_GRANT;
						rsp_d.granted_voice = 6'(tail.free_idx);
						wr_idx              = tail.free_idx;
						wr_use_en           = 1'b1;
						wr_prio_en          = 1'b1;
					end else if (tail.victim_found) begin
						rsp_d.status        = ST_STEAL_GRANT;
						rsp_d.granted_voice = 6'(tail.victim_idx);
						wr_idx              = tail.victim_idx;
						wr_use_en           = 1'b1;
						wr_prio_en          = 1'b1;
					end else begin
						rsp_d.status = ST_REFUSED;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_prio_q <= new_prio;
		end
	end

	// hold the result until taken; a load wins over a pop in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < VOICES; i++) begin : g_cell
		cell_wr_t cell_wr;

		always_comb begin
			cell_wr.use_en   = wr_use_en && (wr_idx == IDX_W'(i));
			cell_wr.use_val  = wr_use_val;
			cell_wr.prio_en  = wr_prio_en && (wr_idx == IDX_W'(i));
			cell_wr.prio_val = wr_prio_val;
		end

		pva_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.req_prio (scan_prio),
			.scan_in  (chain[i]),
			.wr       (cell_wr),
			.scan_out (chain[i+1])
		);
	end

endmodule
`default_nettype wire

@@ rtl/pva_cell.sv @@
`default_nettype none
module pva_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [pva_pkg::IDX_W-1:0]         idx,
	input  wire logic [pva_pkg::PRIORITY_BITS-1:0] req_prio,
	input  wire pva_pkg::scan_t                    scan_in,
	input  wire pva_pkg::cell_wr_t                 wr,
	output pva_pkg::scan_t                         scan_out
);
	import pva_pkg::*;

	logic                     in_use_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	scan_t                    scan_d;
	scan_t                    scan_q;

	always_comb begin
		scan_d = scan_in;
		// first unused voice along the chain wins
		if (!scan_in.free_found && !in_use_q) begin
			scan_d.free_found = 1'b1;
			scan_d.free_idx   = idx;
		end
		// strict compare keeps the lowest index among equal priorities
		if ((prio_q < req_prio) &&
		    (!scan_in.victim_found || (prio_q < scan_in.victim_prio))) begin
			scan_d.victim_found = 1'b1;
			scan_d.victim_idx   = idx;
			scan_d.victim_prio  = prio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			prio_q   <= '0;
		end else begin
			if (wr.use_en) begin
				in_use_q <= wr.use_val;
			end
			if (wr.prio_en) begin
				prio_q <= wr.prio_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	assign scan_out = scan_q;

endmodule
`default_nettype wire

@@ tb/priority_voice_allocator_tb.sv @@
module priority_voice_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pva_pkg::*;

	localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
	localparam int         RANDOM_ITEMS = 1200;
	localparam int         QUIET_LIMIT  = 3000;
	localparam int         DRAIN_CYCLES = VOICES + 6;
	localparam int         LONG_HOLD    = 600;

	typedef struct {
		req_item_t item;
		bit        wait_idle;
	} send_slot_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	priority_voice_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// voice pool as the allocator should see it
	bit                       voice_busy [VOICES];
	logic [PRIORITY_BITS-1:0] voice_prio [VOICES];

	send_slot_t requests_to_send [$];
	rsp_item_t  answers_due [$];
	send_slot_t next_slot;
	rsp_item_t  due;

	bit       failed         = 1'b0;
	bit       req_taken      = 1'b0;
	int       gap_left       = 0;
	int       burst_left     = 1;
	int       answers_seen   = 0;
	int       quiet_cycles   = 0;
	int       hold_left      = 0;
	bit       long_hold_done = 1'b0;
	int       mode_left      = 0;
	rx_mode_t rx_mode        = RX_STEADY;
	logic [15:0] stall_pattern = 16'b1011_0110_1101_0011;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rsp_item_t allocate_voice(req_item_t r);
		rsp_item_t                ans;
		logic [PRIORITY_BITS-1:0] want;
		int                       pick;
		int                       i;
		ans.status        = ST_REFUSED;
		ans.granted_voice = '0;
		want              = r.priority_req[PRIORITY_BITS-1:0];
		pick              = -1;
		case (r.action)
		ACT_ACQUIRE: begin
			for (i = 0; i < VOICES && pick < 0; i++)
				if (!voice_busy[i])
					pick = i;
			if (pick >= 0) begin
				ans.status = ST_FREE_GRANT;
			end else begin
				// steal the lowest priority strictly below the request, lowest index on ties
				for (i = 0; i < VOICES; i++)
					if (voice_prio[i] < want && (pick < 0 || voice_prio[i] < voice_prio[pick]))
						pick = i;
				if (pick >= 0)
					ans.status = ST_STEAL_GRANT;
			end
			if (pick >= 0) begin
				voice_busy[pick]  = 1'b1;
				voice_prio[pick]  = want;
				ans.granted_voice = 6'(pick);
			end
		end
		ACT_FREE: begin
			if (int'(r.voice) < VOICES)
				voice_busy[r.voice] = 1'b0;
			ans.status = ST_DONE;
		end
		ACT_SET_PRIO: begin
			if (int'(r.voice) < VOICES)
				voice_prio[r.voice] = want;
			ans.status = ST_DONE;
		end
		default: begin
			ans.status = ST_REFUSED;
		end
		endcase
		return ans;
	endfunction

	function automatic void queue_req(logic [1:0] act, logic [5:0] v, logic [7:0] p, bit hold);
		send_slot_t slot;
		slot.item.action       = act;
		slot.item.voice        = v;
		slot.item.priority_req = p;
		slot.wait_idle         = hold;
		requests_to_send.push_back(slot);
	endfunction

	function automatic logic [7:0] rand_prio();
		case ($urandom_range(0, 7))
		0:       return 8'd0;
		1:       return 8'd255;
		2:       return 8'($urandom_range(0, 3));
		default: return 8'($urandom);
		endcase
	endfunction

	// sender: present items from the queue in bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (requests_to_send.size() == 0 ||
			             (requests_to_send[0].wait_idle && answers_due.size() != 0)) begin
				req_valid <= 1'b0;
			end else begin
				next_slot = requests_to_send.pop_front();
				req       <= next_slot.item;
				req_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90)
					                                         : $urandom_range(0, 3);
				end
			end
		end
	end

	// receiver: change stall pattern now and then, and hold off once for a long stretch
	always @(negedge clk) begin
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!long_hold_done && answers_seen >= 400) begin
			long_hold_done = 1'b1;
			hold_left      = LONG_HOLD;
			rsp_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			case (rx_mode)
			RX_STEADY:  rsp_ready <= 1'b1;
			RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:  rsp_ready <= ($urandom_range(0, 3) == 0);
			default:    rsp_ready <= stall_pattern[0];
			endcase
		end
	end

	// check results, predict accepted items, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result: status %0d voice %0d",
					         $time, rsp.status, rsp.granted_voice);
					failed = 1'b1;
				end else begin
					due = answers_due.pop_front();
					if (rsp.status !== due.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
						         $time, due.status, rsp.status);
						failed = 1'b1;
					end
					if (rsp.granted_voice !== due.granted_voice) begin
						$display("%0t: granted_voice mismatch: expected %0d, actual %0d",
						         $time, due.granted_voice, rsp.granted_voice);
						failed = 1'b1;
					end
				end
			end
			if (req_valid && req_ready) begin
				req_taken = 1'b1;
				answers_due.push_back(allocate_voice(req));
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
					$display("** priority_voice_allocator: FAILED **");
					$finish;
				end
			end
		end
	end

	initial begin
		int phase;
		int len;
		int k;
		int pick;
		int random_items;
		bit hold;
		bit narrow;
		bit first;

		for (k = 0; k < VOICES; k++) begin
			voice_busy[k] = 1'b0;
			voice_prio[k] = '0;
		end

		queue_req(ACT_ACQUIRE,  6'd0,  8'd0,   1'b0);
		queue_req(ACT_ACQUIRE,  6'd63, 8'd255, 1'b0);
		queue_req(ACT_ACQUIRE,  6'd0,  8'd128, 1'b0);
		queue_req(ACT_FREE,     6'd1,  8'd0,   1'b0);
		queue_req(ACT_ACQUIRE,  6'd0,  8'd7,   1'b0);
		// free and re-prioritise a voice nobody holds
		queue_req(ACT_FREE,     6'd63, 8'd255, 1'b0);
		queue_req(ACT_SET_PRIO, 6'd63, 8'd255, 1'b0);
		queue_req(ACT_SET_PRIO, 6'd0,  8'd0,   1'b0);
		queue_req(ACT_UNKNOWN,  6'd63, 8'd255, 1'b0);
		queue_req(ACT_UNKNOWN,  6'd0,  8'd0,   1'b0);
		queue_req(ACT_FREE,     6'd0,  8'd0,   1'b0);
		queue_req(ACT_FREE,     6'd0,  8'd0,   1'b0);
		queue_req(ACT_ACQUIRE,  6'h2A, 8'd1,   1'b0);
		queue_req(ACT_SET_PRIO, 6'd2,  8'hAA,  1'b0);
		queue_req(ACT_SET_PRIO, 6'd2,  8'h55,  1'b0);
		queue_req(ACT_FREE,     6'h2A, 8'hAA,  1'b0);
		queue_req(ACT_FREE,     6'h15, 8'h55,  1'b0);
		queue_req(ACT_ACQUIRE,  6'h15, 8'd254, 1'b0);

		// mix runs that fill the pool (so that stealing and refusal happen) with churn
		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			hold = (phase == 5) || ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 2) == 0) begin
				narrow = 1'($urandom_range(0, 1));
				len    = $urandom_range(60, 72);
				for (k = 0; k < len; k++)
					queue_req(ACT_ACQUIRE, 6'($urandom),
					          narrow ? 8'($urandom_range(0, 3)) : rand_prio(),
					          hold && k == 0);
				random_items += len;
			end else begin
				len = $urandom_range(20, 80);
				for (k = 0; k < len; k++) begin
					pick  = $urandom_range(0, 99);
					first = hold && k == 0;
					if (pick < 45)
						queue_req(ACT_ACQUIRE, 6'($urandom), rand_prio(), first);
					else if (pick < 70)
						queue_req(ACT_FREE, 6'($urandom), 8'($urandom), first);
					else if (pick < 93)
						queue_req(ACT_SET_PRIO, 6'($urandom), rand_prio(), first);
					else
						queue_req(ACT_UNKNOWN, 6'($urandom), 8'($urandom), first);
					if (pick < 93)
						random_items++;
				end
			end
			phase++;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (requests_to_send.size() != 0 || req_valid || answers_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed)
			$display("** priority_voice_allocator: PASSED **");
		else
			$display("** priority_voice_allocator: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pva_pkg.sv
rtl/pva_cell.sv
rtl/priority_voice_allocator.sv
tb/priority_voice_allocator_tb.sv
